// ===== src/bfd_pkg.sv =====
// ---------------------------------------------------------------------------
// bfd_pkg - shared types and constants of the bracket frame deframer
// Command and result codes, parser phases and the records carried between
// the front end, the parser and the result queue.
// ---------------------------------------------------------------------------
package bfd_pkg;

   localparam int LENGTH_BYTES = 4;   // bytes in the length field, 1..4
   localparam int SUM_BYTES    = 2;   // bytes in the checksum field, 1..2

   localparam int LEN_W = 32;
   localparam int SUM_W = 16;

   localparam logic [SUM_W-1:0] SUM_MASK = (SUM_BYTES >= 2) ? 16'hFFFF : 16'h00FF;

   localparam logic [7:0] START_CHAR_RESET = 8'd91;
   localparam logic [7:0] END_CHAR_RESET   = 8'd93;

   typedef enum logic [1:0] {
      CMD_BYTE = 2'd0,
      CMD_ACK  = 2'd1,
      CMD_RST  = 2'd2,
      CMD_NOP  = 2'd3
   } command_type;

   typedef enum logic [0:0] {
      CSR_START_CHAR = 1'b0,
      CSR_END_CHAR   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_TYPE = 3'd1,
      PH_LEN  = 3'd2,
      PH_DATA = 3'd3,
      PH_SUM  = 3'd4,
      PH_END  = 3'd5
   } phase_type;

   typedef enum logic [3:0] {
      ST_CONSUMED = 4'd0,
      ST_PAYLOAD  = 4'd1,
      ST_GOOD     = 4'd2,
      ST_SUMERR   = 4'd3,
      ST_ENDERR   = 4'd4,
      ST_DROPPED  = 4'd5,
      ST_ACKED    = 4'd6,
      ST_NONE     = 4'd7,
      ST_RESET    = 4'd8
   } status_type;

   typedef struct packed {
      command_type kind;
      logic [7:0]  data;
      logic        last;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  payload;
      logic [7:0]  ftype;
   } rsp_type;

endpackage

// ===== src/bfd_front.sv =====
// ---------------------------------------------------------------------------
// bfd_front - request intake
// Decodes each request into a command record and holds it in a two-entry
// queue until the parser takes it.
// ---------------------------------------------------------------------------
module bfd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_command,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_chunk_last,
   output logic                 cmd_valid,
   output bfd_pkg::cmd_type     cmd,
   input  logic                 cmd_pop
);

   bfd_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;
   bfd_pkg::cmd_type decoded;

   always_comb begin
      decoded.data = req_data_byte;
      decoded.last = req_chunk_last;
      case (req_command)
         bfd_pkg::CMD_BYTE: decoded.kind = bfd_pkg::CMD_BYTE;
         bfd_pkg::CMD_ACK:  decoded.kind = bfd_pkg::CMD_ACK;
         bfd_pkg::CMD_RST:  decoded.kind = bfd_pkg::CMD_RST;
         default:           decoded.kind = bfd_pkg::CMD_NOP;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== src/bfd_rsp_queue.sv =====
// ---------------------------------------------------------------------------
// bfd_rsp_queue - result queue
// Two-entry queue between the parser and the response port, so the parser
// keeps going while a result waits to be popped.
// ---------------------------------------------------------------------------
module bfd_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_push,
   input  bfd_pkg::rsp_type     rsp_in,
   output logic                 rsp_q_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output bfd_pkg::rsp_type     rsp_head
);

   bfd_pkg::rsp_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign rsp_q_full = (count_ff == 2'd2);
   assign rsp_empty  = (count_ff == 2'd0);
   assign rsp_head   = entry_ff[rd_ptr_ff];
   assign do_push    = rsp_push && !rsp_q_full;
   assign do_pop     = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// ===== src/bfd_back.sv =====
// ---------------------------------------------------------------------------
// bfd_back - frame parser
// Executes one command record per cycle, while the result queue has room,
// against the frame state and start/end bytes, giving one result for each.
// ---------------------------------------------------------------------------
module bfd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 cmd_valid,
   input  bfd_pkg::cmd_type     cmd,
   output logic                 cmd_pop,
   output logic                 rsp_push,
   output bfd_pkg::rsp_type     rsp,
   input  logic                 rsp_q_full
);

   logic [7:0]                  start_char_ff, end_char_ff;
   bfd_pkg::phase_type          phase_ff, phase_in;
   logic [1:0]                  fbc_ff, fbc_in;
   logic [bfd_pkg::LEN_W-1:0]   exp_len_ff, exp_len_in;
   logic [bfd_pkg::LEN_W-1:0]   pay_cnt_ff, pay_cnt_in;
   logic [bfd_pkg::SUM_W-1:0]   run_sum_ff, run_sum_in;
   logic [bfd_pkg::SUM_W-1:0]   rcv_sum_ff, rcv_sum_in;
   logic [7:0]                  held_type_ff, held_type_in;
   logic                        held_ff, held_in;
   logic                        chunk_start_ff, chunk_start_in;
   logic                        dropping_ff, dropping_in;

   logic                        fire;
   logic                        drop_now;
   logic [1:0]                  fbc_inc;
   logic                        len_done, data_done, sum_done, sum_ok;
   logic                        end_ok, start_hit;
   logic [bfd_pkg::LEN_W-1:0]   exp_shift, pay_inc;
   logic [bfd_pkg::SUM_W-1:0]   rcv_shift, sum_add;
   logic [7:0]                  b;

   assign fire     = cmd_valid && !rsp_q_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;
   assign b        = cmd.data;

   // a chunk's fate is fixed by whether a frame is held at its first byte
   assign drop_now  = chunk_start_ff ? held_ff : dropping_ff;
   assign fbc_inc   = fbc_ff + 2'd1;
   assign len_done  = (fbc_inc == 2'd0) || ({1'b0, fbc_inc} >= 3'(bfd_pkg::LENGTH_BYTES));
   assign sum_done  = {1'b0, fbc_inc} >= 3'(bfd_pkg::SUM_BYTES);
   assign exp_shift = {exp_len_ff[bfd_pkg::LEN_W-9:0], b};
   assign pay_inc   = pay_cnt_ff + 32'd1;
   assign data_done = pay_inc >= exp_len_ff;
   assign sum_add   = run_sum_ff + {8'd0, b};
   assign rcv_shift = {rcv_sum_ff[bfd_pkg::SUM_W-9:0], b};
   assign sum_ok    = (rcv_shift & bfd_pkg::SUM_MASK) == (run_sum_ff & bfd_pkg::SUM_MASK);
   assign end_ok    = (b == end_char_ff);
   assign start_hit = (b == start_char_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (cmd.kind)
            bfd_pkg::CMD_BYTE: begin
               if (!drop_now) begin
                  case (phase_ff)
                     bfd_pkg::PH_TYPE: phase_in = bfd_pkg::PH_LEN;
                     bfd_pkg::PH_LEN: begin
                        if (len_done) begin
                           phase_in = (exp_shift == '0) ? bfd_pkg::PH_SUM : bfd_pkg::PH_DATA;
                        end
                     end
                     bfd_pkg::PH_DATA: begin
                        if (data_done) phase_in = bfd_pkg::PH_SUM;
                     end
                     bfd_pkg::PH_SUM: begin
                        if (sum_done) phase_in = sum_ok ? bfd_pkg::PH_END : bfd_pkg::PH_HUNT;
                     end
                     bfd_pkg::PH_END: phase_in = bfd_pkg::PH_HUNT;
                     default: begin
                        if (start_hit) phase_in = bfd_pkg::PH_TYPE;
                     end
                  endcase
               end
            end
            bfd_pkg::CMD_RST: phase_in = bfd_pkg::PH_HUNT;
            default:          phase_in = phase_ff;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      fbc_in         = fbc_ff;
      exp_len_in     = exp_len_ff;
      pay_cnt_in     = pay_cnt_ff;
      run_sum_in     = run_sum_ff;
      rcv_sum_in     = rcv_sum_ff;
      held_type_in   = held_type_ff;
      held_in        = held_ff;
      chunk_start_in = chunk_start_ff;
      dropping_in    = dropping_ff;
      rsp.status     = bfd_pkg::ST_CONSUMED;
      rsp.payload    = 8'd0;
      rsp.ftype      = 8'd0;
      if (fire) begin
         case (cmd.kind)
            bfd_pkg::CMD_BYTE: begin
               dropping_in    = drop_now;
               chunk_start_in = 1'b0;
               if (drop_now) begin
                  rsp.status = bfd_pkg::ST_DROPPED;
               end else begin
                  case (phase_ff)
                     bfd_pkg::PH_TYPE: begin
                        held_type_in = b;
                        fbc_in       = 2'd0;
                        exp_len_in   = '0;
                     end
                     bfd_pkg::PH_LEN: begin
                        exp_len_in = exp_shift;
                        fbc_in     = fbc_inc;
                        if (len_done) begin
                           fbc_in     = 2'd0;
                           pay_cnt_in = '0;
                        end
                     end
                     bfd_pkg::PH_DATA: begin
                        run_sum_in  = sum_add;
                        pay_cnt_in  = pay_inc;
                        rsp.status  = bfd_pkg::ST_PAYLOAD;
                        rsp.payload = b;
                     end
                     bfd_pkg::PH_SUM: begin
                        rcv_sum_in = rcv_shift;
                        fbc_in     = fbc_inc;
                        if (sum_done) begin
                           fbc_in     = 2'd0;
                           rcv_sum_in = '0;
                           run_sum_in = '0;
                           if (!sum_ok) begin
                              exp_len_in   = '0;
                              pay_cnt_in   = '0;
                              held_type_in = 8'd0;
                              held_in      = 1'b0;
                              rsp.status   = bfd_pkg::ST_SUMERR;
                           end
                        end
                     end
                     bfd_pkg::PH_END: begin
                        exp_len_in = '0;
                        pay_cnt_in = '0;
                        if (end_ok) begin
                           held_in    = 1'b1;
                           rsp.status = bfd_pkg::ST_GOOD;
                           rsp.ftype  = held_type_ff;
                        end else begin
                           fbc_in       = 2'd0;
                           run_sum_in   = '0;
                           rcv_sum_in   = '0;
                           held_type_in = 8'd0;
                           held_in      = 1'b0;
                           rsp.status   = bfd_pkg::ST_ENDERR;
                        end
                     end
                     default: begin
                        if (start_hit) begin
                           fbc_in     = 2'd0;
                           pay_cnt_in = '0;
                        end
                     end
                  endcase
               end
               if (cmd.last) begin
                  chunk_start_in = 1'b1;
                  dropping_in    = 1'b0;
               end
            end
            bfd_pkg::CMD_ACK: begin
               if (held_ff) begin
                  rsp.status   = bfd_pkg::ST_ACKED;
                  rsp.ftype    = held_type_ff;
                  held_in      = 1'b0;
                  held_type_in = 8'd0;
               end else begin
                  rsp.status = bfd_pkg::ST_NONE;
               end
            end
            bfd_pkg::CMD_RST: begin
               fbc_in         = 2'd0;
               exp_len_in     = '0;
               pay_cnt_in     = '0;
               run_sum_in     = '0;
               rcv_sum_in     = '0;
               held_type_in   = 8'd0;
               held_in        = 1'b0;
               chunk_start_in = 1'b1;
               dropping_in    = 1'b0;
               rsp.status     = bfd_pkg::ST_RESET;
            end
            default: rsp.status = bfd_pkg::ST_CONSUMED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff  <= bfd_pkg::START_CHAR_RESET;
         end_char_ff    <= bfd_pkg::END_CHAR_RESET;
         phase_ff       <= bfd_pkg::PH_HUNT;
         fbc_ff         <= 2'd0;
         exp_len_ff     <= '0;
         pay_cnt_ff     <= '0;
         run_sum_ff     <= '0;
         rcv_sum_ff     <= '0;
         held_type_ff   <= 8'd0;
         held_ff        <= 1'b0;
         chunk_start_ff <= 1'b1;
         dropping_ff    <= 1'b0;
      end else begin
         if (csr_we && (csr_index == bfd_pkg::CSR_START_CHAR)) start_char_ff <= csr_wdata;
         if (csr_we && (csr_index == bfd_pkg::CSR_END_CHAR))   end_char_ff   <= csr_wdata;
         phase_ff       <= phase_in;
         fbc_ff         <= fbc_in;
         exp_len_ff     <= exp_len_in;
         pay_cnt_ff     <= pay_cnt_in;
         run_sum_ff     <= run_sum_in;
         rcv_sum_ff     <= rcv_sum_in;
         held_type_ff   <= held_type_in;
         held_ff        <= held_in;
         chunk_start_ff <= chunk_start_in;
         dropping_ff    <= dropping_in;
      end
   end

   // payload phase always has bytes still owed
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bfd_pkg::PH_DATA) |-> (pay_cnt_ff < exp_len_ff))
      else $error("payload count overran expected length");

   a_good_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp.status == bfd_pkg::ST_GOOD) |=> (held_ff && phase_ff == bfd_pkg::PH_HUNT))
      else $error("good frame not held");

   a_rst_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd.kind == bfd_pkg::CMD_RST) |=>
         (phase_ff == bfd_pkg::PH_HUNT && !held_ff && chunk_start_ff && !dropping_ff))
      else $error("receiver reset incomplete");

   a_drop_only_held: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd.kind == bfd_pkg::CMD_BYTE && chunk_start_ff && !held_ff) |->
         (rsp.status != bfd_pkg::ST_DROPPED))
      else $error("chunk dropped with nothing held");

endmodule

// ===== src/bracket_frame_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// bracket_frame_deframer_unit - receive deframer for a bracketed byte stream
// Usage:
//   Requests enter as a queue: present req_command/req_data_byte/
//   req_chunk_last with req_push; the request is taken when req_full is low.
//   Command 0 is a received byte, 1 acknowledges a held frame, 2 resets the
//   receiver. Every request gives exactly one result on the rsp_ ports,
//   readable while rsp_empty is low and removed with rsp_pop.
//   csr_we writes csr_wdata to the start byte (index 0) or end byte
//   (index 1); write only while no request is in flight.
//   Each request passes the request queue, the combinational parser and
//   the result queue before its result can be popped.
//   Throughput: one request per cycle while results drain; the parser
//   handles one byte per cycle with a single 32-bit payload count compare.
//   If the result side stalls, two results queue up, then the parser stops
//   and the two-entry request queue fills and raises req_full.
//   After reset the parser hunts for the start byte, nothing is held and
//   the start/end bytes are 91 and 93.
// ---------------------------------------------------------------------------
module bracket_frame_deframer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_chunk_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [3:0] rsp_status,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_frame_type,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic             cmd_valid, cmd_pop;
   bfd_pkg::cmd_type cmd;
   logic             rsp_push, rsp_q_full;
   bfd_pkg::rsp_type rsp_next, rsp_head;

   bfd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_data_byte  (req_data_byte),
      .req_chunk_last (req_chunk_last),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   bfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_push   (rsp_push),
      .rsp        (rsp_next),
      .rsp_q_full (rsp_q_full)
   );

   bfd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .rsp_push   (rsp_push),
      .rsp_in     (rsp_next),
      .rsp_q_full (rsp_q_full),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_head   (rsp_head)
   );

   assign rsp_status       = rsp_head.status;
   assign rsp_payload_byte = rsp_head.payload;
   assign rsp_frame_type   = rsp_head.ftype;

endmodule

// ===== verif/bracket_frame_deframer_unit_test.sv =====
// ---------------------------------------------------------------------------
// bracket_frame_deframer_unit_test - self-checking bench for the deframer
// Feeds bytes, acknowledges and receiver resets through the request queue.
// Every request is predicted by a model of the frame parser in the bench and
// checked field by field against the result queue. Four phases run with
// different start/end bytes and differing mixes of idle and stall rates.
// ---------------------------------------------------------------------------
module bracket_frame_deframer_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   import bfd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 400;

   typedef enum {FRAME_OK, FRAME_BAD_SUM, FRAME_BAD_END} frame_fault_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [1:0] req_command = CMD_NOP;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_chunk_last = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [3:0] rsp_status;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_frame_type;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_START_CHAR;
   logic [7:0] csr_wdata = 8'h00;

   bracket_frame_deframer_unit DUT (.*);

   // parser model state
   logic [7:0]  start_byte = START_CHAR_RESET;
   logic [7:0]  end_byte   = END_CHAR_RESET;
   phase_type   rx_phase   = PH_HUNT;
   logic [1:0]  fld_count  = '0;
   logic [31:0] frame_len  = '0;
   logic [31:0] pay_count  = '0;
   logic [15:0] sum_acc    = '0;
   logic [15:0] sum_rx     = '0;
   logic [7:0]  held_ftype = '0;
   logic        held_flag  = 1'b0;
   logic        chunk_start = 1'b1;
   logic        chunk_drop  = 1'b0;

   cmd_type     request_backlog[$];
   rsp_type     predicted_results[$];
   cmd_type     on_port;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned queued = 0;
   int unsigned accepted = 0;
   int unsigned n_checked = 0;
   int unsigned n_good = 0;
   int unsigned n_sumerr = 0;
   int unsigned n_enderr = 0;
   int unsigned n_dropped = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;

   function void clear_frame_state();
      rx_phase   = PH_HUNT;
      fld_count  = '0;
      frame_len  = '0;
      pay_count  = '0;
      sum_acc    = '0;
      sum_rx     = '0;
      held_ftype = '0;
      held_flag  = 1'b0;
   endfunction

   function rsp_type deframe_step(input cmd_type rq);
      rsp_type r;
      r = '{ST_CONSUMED, 8'h00, 8'h00};
      case (rq.kind)
         CMD_BYTE: begin
            // a chunk that opens while a frame is held goes in the bin whole
            if (chunk_start)
               chunk_drop = held_flag;
            chunk_start = 1'b0;
            if (chunk_drop) begin
               r.status = ST_DROPPED;
            end else begin
               case (rx_phase)
                  PH_TYPE: begin
                     held_ftype = rq.data;
                     fld_count  = '0;
                     frame_len  = '0;
                     rx_phase   = PH_LEN;
                  end
                  PH_LEN: begin
                     frame_len = {frame_len[23:0], rq.data};
                     fld_count = fld_count + 2'd1;
                     if (fld_count == 0 || fld_count >= LENGTH_BYTES) begin
                        fld_count = '0;
                        pay_count = '0;
                        rx_phase  = (frame_len == 0) ? PH_SUM : PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     sum_acc   = sum_acc + rq.data;
                     pay_count = pay_count + 1;
                     if (pay_count >= frame_len)
                        rx_phase = PH_SUM;
                     r.status  = ST_PAYLOAD;
                     r.payload = rq.data;
                  end
                  PH_SUM: begin
                     sum_rx    = {sum_rx[7:0], rq.data};
                     fld_count = fld_count + 2'd1;
                     if (fld_count >= SUM_BYTES) begin
                        if ((sum_rx & SUM_MASK) == (sum_acc & SUM_MASK)) begin
                           fld_count = '0;
                           sum_rx    = '0;
                           sum_acc   = '0;
                           rx_phase  = PH_END;
                        end else begin
                           clear_frame_state();
                           r.status = ST_SUMERR;
                        end
                     end
                  end
                  PH_END: begin
                     if (rq.data == end_byte) begin
                        rx_phase  = PH_HUNT;
                        held_flag = 1'b1;
                        frame_len = '0;
                        pay_count = '0;
                        r.status  = ST_GOOD;
                        r.ftype   = held_ftype;
                     end else begin
                        clear_frame_state();
                        r.status = ST_ENDERR;
                     end
                  end
                  default: begin
                     if (rq.data == start_byte) begin
                        rx_phase  = PH_TYPE;
                        fld_count = '0;
                        pay_count = '0;
                     end
                  end
               endcase
            end
            if (rq.last) begin
               chunk_start = 1'b1;
               chunk_drop  = 1'b0;
            end
         end
         CMD_ACK: begin
            if (held_flag) begin
               r.status   = ST_ACKED;
               r.ftype    = held_ftype;
               held_flag  = 1'b0;
               held_ftype = '0;
            end else begin
               r.status = ST_NONE;
            end
         end
         CMD_RST: begin
            clear_frame_state();
            chunk_start = 1'b1;
            chunk_drop  = 1'b0;
            r.status    = ST_RESET;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---- stimulus helpers ----
   function bit chunk_break();
      return $urandom_range(9) == 0;
   endfunction

   task add_req(input command_type k, input logic [7:0] d, input logic l);
      request_backlog.push_back('{k, d, l});
      queued++;
   endtask

   task add_frame(input logic [7:0] ftype, input int unsigned len,
                  input frame_fault_type fault, input bit end_last);
      logic [15:0] total;
      logic [31:0] l32;
      logic [7:0]  b;
      int          i;
      total = '0;
      l32   = len;
      add_req(CMD_BYTE, start_byte, chunk_break());
      add_req(CMD_BYTE, ftype, chunk_break());
      for (i = LENGTH_BYTES - 1; i >= 0; i--)
         add_req(CMD_BYTE, 8'(l32 >> (8 * i)), chunk_break());
      for (i = 0; i < int'(len); i++) begin
         b = 8'($urandom);
         total = total + b;
         add_req(CMD_BYTE, b, chunk_break());
      end
      if (fault == FRAME_BAD_SUM)
         total = total ^ 16'($urandom_range(1, 65535));
      for (i = SUM_BYTES - 1; i >= 0; i--)
         add_req(CMD_BYTE, 8'(total >> (8 * i)), chunk_break());
      b = (fault == FRAME_BAD_END) ? end_byte ^ 8'($urandom_range(1, 255)) : end_byte;
      add_req(CMD_BYTE, b, end_last);
   endtask

   task random_traffic(input int unsigned n);
      int unsigned stop;
      int unsigned r;
      int unsigned k;
      int unsigned len;
      frame_fault_type fault;
      stop = queued + n;
      while (queued < stop) begin
         r = $urandom_range(99);
         if (r < 66) begin
            repeat ($urandom_range(0, 2))
               add_req(CMD_BYTE, 8'($urandom), chunk_break());
            k = $urandom_range(99);
            if (k < 45)
               len = $urandom_range(0, 3);
            else if (k < 90)
               len = $urandom_range(4, 24);
            else if (k < 98)
               len = $urandom_range(25, 80);
            else
               len = $urandom_range(250, 300);
            k = $urandom_range(99);
            fault = (k < 80) ? FRAME_OK : (k < 90) ? FRAME_BAD_SUM : FRAME_BAD_END;
            add_frame(8'($urandom), len, fault, $urandom_range(9) < 7);
            if ($urandom_range(99) < 65)
               add_req(CMD_ACK, 8'($urandom), 1'($urandom));
         end else if (r < 76) begin
            add_req(CMD_ACK, 8'($urandom), 1'($urandom));
         end else if (r < 80) begin
            add_req(CMD_RST, 8'($urandom), 1'($urandom));
         end else if (r < 83) begin
            add_req(CMD_NOP, 8'($urandom), 1'($urandom));
         end else if (r < 92) begin
            repeat ($urandom_range(1, 6))
               add_req(CMD_BYTE, 8'($urandom), chunk_break());
         end else begin
            // frame cut short somewhere after its type byte, length fully random
            add_req(CMD_BYTE, start_byte, chunk_break());
            add_req(CMD_BYTE, 8'($urandom), chunk_break());
            repeat ($urandom_range(0, LENGTH_BYTES))
               add_req(CMD_BYTE, 8'($urandom), chunk_break());
            repeat ($urandom_range(0, 3))
               add_req(CMD_BYTE, 8'($urandom), chunk_break());
            add_req(CMD_RST, 8'($urandom), 1'($urandom));
         end
      end
   endtask

   task drain_pipeline();
      while (request_backlog.size() != 0 || req_push || predicted_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task set_delimiters(input logic [7:0] s, input logic [7:0] e);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_START_CHAR;
      csr_wdata <= s;
      start_byte = s;
      @(posedge clock);
      csr_index <= CSR_END_CHAR;
      csr_wdata <= e;
      end_byte = e;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // ---- clock ----
   initial begin
      forever #1 clock = ~clock;
   end

   // ---- request driver ----
   always @(posedge clock) begin : driver
      cmd_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predicted_results.push_back(deframe_step(on_port));
            accepted++;
         end
         if (!req_push || !req_full) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = request_backlog.pop_front();
               req_push       <= 1'b1;
               req_command    <= nxt.kind;
               req_data_byte  <= nxt.data;
               req_chunk_last <= nxt.last;
               on_port        <= nxt;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // ---- result monitor ----
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (predicted_results.size() == 0) begin
               errors++;
               $display("%0t: result with no request outstanding: status %0d",
                        $time, rsp_status);
            end else begin
               want = predicted_results.pop_front();
               n_checked++;
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_payload_byte !== want.payload) begin
                  errors++;
                  $display("%0t: payload byte expected %0d, got %0d",
                           $time, want.payload, rsp_payload_byte);
               end
               if (rsp_frame_type !== want.ftype) begin
                  errors++;
                  $display("%0t: frame type expected %0d, got %0d",
                           $time, want.ftype, rsp_frame_type);
               end
               case (want.status)
                  ST_GOOD:    n_good++;
                  ST_SUMERR:  n_sumerr++;
                  ST_ENDERR:  n_enderr++;
                  ST_DROPPED: n_dropped++;
                  default: ;
               endcase
            end
         end
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding",
                  $time, predicted_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---- sequence ----
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty payload, good frame, dropped chunk, acks, unused
      // command, checksum failure and receiver reset
      add_req(CMD_BYTE, 8'h00, 1'b0);
      add_frame(8'hFF, 0, FRAME_OK, 1'b1);
      add_req(CMD_BYTE, start_byte, 1'b0);
      add_req(CMD_BYTE, 8'hFF, 1'b1);
      add_req(CMD_ACK, 8'h00, 1'b0);
      add_req(CMD_ACK, 8'hFF, 1'b1);
      add_req(CMD_NOP, 8'hA5, 1'b1);
      add_frame(8'h5A, 0, FRAME_BAD_SUM, 1'b1);
      add_req(CMD_RST, 8'h5A, 1'b0);
      random_traffic(PHASE_ITEMS);
      drain_pipeline();

      set_delimiters(8'h00, 8'hFF);
      idle_pct  = 55;
      stall_pct = 0;
      random_traffic(PHASE_ITEMS);
      drain_pipeline();

      set_delimiters(8'hFF, 8'h00);
      idle_pct  = 0;
      stall_pct = 55;
      random_traffic(PHASE_ITEMS);
      drain_pipeline();

      // start and end bytes occasionally the same value
      begin : last_phase
         logic [7:0] s;
         s = 8'($urandom);
         set_delimiters(s, ($urandom_range(9) == 0) ? s : 8'($urandom));
      end
      idle_pct  = 38;
      stall_pct = 38;
      random_traffic(PHASE_ITEMS);
      drain_pipeline();
      repeat (6) @(posedge clock);

      $display("%0d requests over four delimiter/flow-control settings, %0d results checked",
               accepted, n_checked);
      $display("good frames %0d, checksum errors %0d, end errors %0d, dropped bytes %0d",
               n_good, n_sumerr, n_enderr, n_dropped);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
